[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/fcc_pkg.sv]
// ---------------------------------------------------------------------------
// fcc_pkg
// Types, frame layout constants and CRC-8 helper for the frame checker.
// ---------------------------------------------------------------------------
package fcc_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [7:0]      CRC_POLY        = 8'h07;
  localparam logic [15:0]     MAX_PAYLOAD_RST = 16'd1050;

  // byte positions within a frame
  localparam logic [PosW-1:0] POS_VERSION  = 17'd3;
  localparam logic [PosW-1:0] POS_COMMAND  = 17'd4;
  localparam logic [PosW-1:0] POS_DEVICE   = 17'd5;
  localparam logic [PosW-1:0] POS_LEN_HEAD = 17'd6;
  localparam logic [PosW-1:0] POS_LEN_LAST = 17'd9;
  localparam logic [PosW-1:0] POS_PKT_HI   = 17'd14;
  localparam logic [PosW-1:0] POS_PKT_LO   = 17'd15;
  localparam logic [PosW-1:0] POS_PAYLOAD  = 17'd16;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CRC_ERR = 2'd1,
    STAT_LEN_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic        is_payload;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [7:0]  command;
    logic [7:0]  device_code;
    logic [15:0] packet_number;
    logic [15:0] frame_length;
  } res_t;

  // CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_len(input logic [31:0] len);
    return (|len[31:16]) ? 16'hFFFF : len[15:0];
  endfunction

endpackage

[rtl/fcc_rx_if.sv]
// ---------------------------------------------------------------------------
// fcc_rx_if
// Byte stream channel into the frame checker.
// ---------------------------------------------------------------------------
interface fcc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/fcc_res_if.sv]
// ---------------------------------------------------------------------------
// fcc_res_if
// Result channel out of the frame checker: payload bytes and verdicts.
// ---------------------------------------------------------------------------
interface fcc_res_if;
  logic        valid;
  logic        ready;
  logic        is_payload;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic [7:0]  command;
  logic [7:0]  device_code;
  logic [15:0] packet_number;
  logic [15:0] frame_length;

  modport source (output valid, output is_payload, output payload_byte, output status,
                  output command, output device_code, output packet_number,
                  output frame_length, input ready);
  modport sink   (input valid, input is_payload, input payload_byte, input status,
                  input command, input device_code, input packet_number,
                  input frame_length, output ready);
endinterface

[rtl/fcc_out_buf.sv]
// ---------------------------------------------------------------------------
// fcc_out_buf
// Two-entry result buffer: output register plus skid slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcc_out_buf
  import fcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_t      push_data_i,
  output logic      full_o,
  fcc_res_if.source res_o
);

  res_t       ent_q [2];
  res_t       ent_d [2];
  logic [1:0] count_q, count_d;
  logic       pop;
  logic       wr_idx;

  assign pop    = res_o.valid && res_o.ready;
  assign full_o = (count_q == 2'd2);
  // slot the new entry lands in, after any pop this cycle
  assign wr_idx = (count_q - {1'b0, pop}) != 2'd0;

  always_comb begin
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (push_i) begin
      ent_d[wr_idx] = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign res_o.valid         = (count_q != 2'd0);
  assign res_o.is_payload    = ent_q[0].is_payload;
  assign res_o.payload_byte  = ent_q[0].payload_byte;
  assign res_o.status        = ent_q[0].status;
  assign res_o.command       = ent_q[0].command;
  assign res_o.device_code   = ent_q[0].device_code;
  assign res_o.packet_number = ent_q[0].packet_number;
  assign res_o.frame_length  = ent_q[0].frame_length;

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q == 2'd3)
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && (count_q == 2'd0))

endmodule

[rtl/frame_checker_crc8.sv]
// ---------------------------------------------------------------------------
// frame_checker_crc8
// Byte-serial framed packet checker with CRC-8 (poly 0x07, init 0).
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle: rx_i is ready whenever the two-entry
// result buffer has a free slot, so the rate is one byte per cycle as long
// as results are taken. Each payload byte and each verdict appears on res_o
// in the cycle after the transfer of the byte that caused it when no older
// result is waiting, later otherwise. Header bytes, the
// repeated length and the packet number give no result. A length of zero or
// above max_payload gives a length-error verdict straight after the length
// field and the next byte starts a new frame. max_payload is written through
// cfg_we_i/cfg_wdata_i and resets to 1050.
`include "assert_macros.svh"

module frame_checker_crc8
  import fcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  fcc_rx_if.sink      rx_i,
  fcc_res_if.source   res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      crc_q, crc_d;
  logic [31:0]     len_q, len_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      dev_q, dev_d;
  logic [15:0]     pkt_q, pkt_d;
  logic [15:0]     max_q;

  logic            buf_full;
  logic            accept;
  logic            push;
  res_t            push_res;

  logic [7:0]      b;
  logic [PosW-1:0] pos_off;
  logic            is_check;
  logic [31:0]     len_new;
  logic            len_bad;

  assign rx_i.ready = !buf_full;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign pos_off  = pos_q - POS_PAYLOAD;
  assign is_check = (pos_q >= POS_PAYLOAD) && (len_q[31:PosW] == '0)
                    && (len_q[PosW-1:0] == pos_off);
  assign len_new  = {len_q[23:0], b};
  assign len_bad  = (len_new == 32'd0) || (len_new > {16'd0, max_q});

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    dev_d    = dev_q;
    pkt_d    = pkt_q;
    push     = 1'b0;
    push_res = '{is_payload: 1'b0, payload_byte: 8'd0, status: STAT_OK,
                 command: cmd_q, device_code: dev_q, packet_number: pkt_q,
                 frame_length: sat_len(len_q)};
    if (accept) begin
      if (is_check) begin
        push            = 1'b1;
        push_res.status = (b == crc_q) ? STAT_OK : STAT_CRC_ERR;
        pos_d           = '0;
        crc_d           = 8'd0;
      end else begin
        if (pos_q >= POS_VERSION) begin
          crc_d = crc8_update(crc_q, b);
        end
        pos_d = pos_q + 1'b1;
        priority if (pos_q == POS_COMMAND) begin
          cmd_d = b;
        end else if (pos_q == POS_DEVICE) begin
          dev_d = b;
        end else if (pos_q >= POS_LEN_HEAD && pos_q <= POS_LEN_LAST) begin
          len_d = len_new;
          if (pos_q == POS_LEN_LAST && len_bad) begin
            push                   = 1'b1;
            push_res.status        = STAT_LEN_ERR;
            push_res.packet_number = 16'd0;
            push_res.frame_length  = sat_len(len_new);
            pos_d                  = '0;
            crc_d                  = 8'd0;
          end
        end else if (pos_q == POS_PKT_HI) begin
          pkt_d = {b, pkt_q[7:0]};
        end else if (pos_q == POS_PKT_LO) begin
          pkt_d = {pkt_q[15:8], b};
        end else if (pos_q >= POS_PAYLOAD) begin
          push                  = 1'b1;
          push_res.is_payload   = 1'b1;
          push_res.payload_byte = b;
        end else begin
          // header bytes, version and repeated length: nothing kept
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= 8'd0;
      len_q <= 32'd0;
      cmd_q <= 8'd0;
      dev_q <= 8'd0;
      pkt_q <= 16'd0;
      max_q <= MAX_PAYLOAD_RST;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      len_q <= len_d;
      cmd_q <= cmd_d;
      dev_q <= dev_d;
      pkt_q <= pkt_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  fcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .full_o      (buf_full),
    .res_o       (res_o)
  );

  // a verdict always closes the frame
  `ASSERT_PROP(a_verdict_restarts, clk_i, rst_ni, (push && !push_res.is_payload) |=> (pos_q == '0))
  // CRC starts at the version byte
  `ASSERT_PROP(a_crc_clear_in_header, clk_i, rst_ni, (pos_q <= POS_VERSION) |-> (crc_q == 8'd0))
  // checked length bounds the position to the check byte
  `ASSERT_NEVER(a_pos_bound, clk_i, rst_ni, pos_q > (POS_PAYLOAD + 17'd65535))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for frame_checker_crc8. It drives well-formed frames
// with random content, plus corrupt check bytes, bad lengths and line noise,
// across several max_payload settings. Both handshakes idle at random. A
// scoreboard class predicts every payload byte and verdict, and compares
// each result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
import fcc_pkg::*;

class frame_scoreboard;
  logic [16:0] pos;
  logic [7:0]  crc;
  logic [31:0] len;
  logic [7:0]  cmd;
  logic [7:0]  dev;
  logic [15:0] pkt;
  logic [15:0] max_payload;
  res_t        pending[$];
  int          errors;
  int          n_payload;
  int          n_ok;
  int          n_crc_err;
  int          n_len_err;

  function new();
    max_payload = MAX_PAYLOAD_RST;
    pos = '0;
    crc = '0;
    len = '0;
    cmd = '0;
    dev = '0;
    pkt = '0;
    errors = 0;
    n_payload = 0;
    n_ok = 0;
    n_crc_err = 0;
    n_len_err = 0;
  endfunction

  // MSB-first CRC-8, one byte
  static function logic [7:0] crc8_next(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function void queue_result(input logic is_pl, input logic [7:0] pb, input status_e st,
                             input logic [15:0] pn);
    res_t r;
    r.is_payload    = is_pl;
    r.payload_byte  = pb;
    r.status        = st;
    r.command       = cmd;
    r.device_code   = dev;
    r.packet_number = pn;
    r.frame_length  = (len > 32'h0000_FFFF) ? 16'hFFFF : len[15:0];
    pending.push_back(r);
  endfunction

  // advance the frame state by one accepted byte
  function void note_byte(input logic [7:0] b);
    logic [16:0] p;
    p = pos;
    if (p >= POS_PAYLOAD && 32'(p - POS_PAYLOAD) == len) begin
      if (b == crc) begin
        n_ok++;
        queue_result(1'b0, 8'h00, STAT_OK, pkt);
      end else begin
        n_crc_err++;
        queue_result(1'b0, 8'h00, STAT_CRC_ERR, pkt);
      end
      pos = '0;
      crc = '0;
      return;
    end
    if (p >= POS_VERSION) crc = crc8_next(crc, b);
    pos = p + 17'd1;
    if (p == POS_COMMAND) begin
      cmd = b;
    end else if (p == POS_DEVICE) begin
      dev = b;
    end else if (p >= POS_LEN_HEAD && p <= POS_LEN_LAST) begin
      len = {len[23:0], b};
      if (p == POS_LEN_LAST && (len == 0 || len > {16'h0000, max_payload})) begin
        // packet number not yet seen, so reported as zero
        n_len_err++;
        queue_result(1'b0, 8'h00, STAT_LEN_ERR, 16'h0000);
        pos = '0;
        crc = '0;
      end
    end else if (p == POS_PKT_HI) begin
      pkt[15:8] = b;
    end else if (p == POS_PKT_LO) begin
      pkt[7:0] = b;
    end else if (p >= POS_PAYLOAD) begin
      n_payload++;
      queue_result(1'b1, b, STAT_OK, pkt);
    end
  endfunction

  function void field_cmp(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(input res_t got);
    res_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 30) $display("%0t: result with nothing pending: %h", $time, got);
      return;
    end
    want = pending.pop_front();
    field_cmp("is_payload", 16'(want.is_payload), 16'(got.is_payload));
    field_cmp("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
    field_cmp("status", 16'(want.status), 16'(got.status));
    field_cmp("command", 16'(want.command), 16'(got.command));
    field_cmp("device_code", 16'(want.device_code), 16'(got.device_code));
    field_cmp("packet_number", want.packet_number, got.packet_number);
    field_cmp("frame_length", want.frame_length, got.frame_length);
  endfunction
endclass

module tb;
  localparam int unsigned CycleLimit = 300000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int unsigned cycle_count = 0;

  fcc_rx_if  rx_if ();
  fcc_res_if res_if ();

  frame_scoreboard sb;
  bit          tx_idle;
  bit          rx_idle;
  int          bytes_sent;
  int          frames_sent;
  logic [7:0]  tx_crc;

  frame_checker_crc8 uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  // one byte transfer, preceded by a random gap while idling is on
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!(rx_if.valid === 1'b1 && rx_if.ready === 1'b1));
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_sum(input logic [7:0] b);
    tx_crc = sb.crc8_next(tx_crc, b);
    send_byte(b);
  endtask

  // whole frame; stops after the length field when the length will be refused
  task automatic send_frame(input logic [31:0] flen, input logic [7:0] cmd,
                            input logic [7:0] dev, input logic [15:0] pkt, input bit corrupt);
    logic [31:0] rep;
    int i;
    rep = ($urandom_range(0, 3) == 0) ? $urandom() : flen;
    tx_crc = 8'h00;
    frames_sent++;
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_sum(8'($urandom_range(0, 255)));
    send_sum(cmd);
    send_sum(dev);
    for (i = 3; i >= 0; i--) send_sum(flen[8*i +: 8]);
    if (flen == 0 || flen > {16'h0000, sb.max_payload}) return;
    for (i = 3; i >= 0; i--) send_sum(rep[8*i +: 8]);
    send_sum(pkt[15:8]);
    send_sum(pkt[7:0]);
    for (i = 0; i < int'(flen); i++) send_sum(8'($urandom_range(0, 255)));
    send_byte(corrupt ? (tx_crc ^ (8'h01 << $urandom_range(0, 7))) : tx_crc);
  endtask

  task automatic write_limit(input logic [15:0] v);
    rx_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_payload = v;
  endtask

  // mostly good frames; some bad check bytes, bad lengths and, with with_noise, noise bursts
  task automatic random_traffic(input int n_bytes, input int len_cap, input bit with_noise);
    int start;
    int sel;
    int cap;
    logic [31:0] flen;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      if (sb.max_payload == 0) cap = len_cap;
      else cap = (int'(sb.max_payload) < len_cap) ? int'(sb.max_payload) : len_cap;
      if (sel == 9 && with_noise) begin
        repeat ($urandom_range(4, 24)) send_byte(8'($urandom_range(0, 255)));
        // resync to a frame boundary
        while (sb.pos != 0) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if (sel == 8) begin
          case ($urandom_range(0, 3))
            0: flen = 32'd0;
            1: flen = {16'h0000, sb.max_payload} + 32'd1;
            2: flen = $urandom() | 32'h0100_0000;
            default: flen = 32'h0001_0000 | $urandom_range(0, 255);
          endcase
        end else if ($urandom_range(0, 7) == 0) begin
          flen = cap;
        end else begin
          flen = $urandom_range(1, (cap < 8) ? cap : 8);
        end
        send_frame(flen, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), sel >= 7);
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    res_t got;
    taken = 0;
    rx_idle = 1'b1;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 6) : 0;
      // long hold-off so the result buffer fills and rx stalls
      if (taken == 60) stall = 80;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      got.is_payload    = res_if.is_payload;
      got.payload_byte  = res_if.payload_byte;
      got.status        = status_e'(res_if.status);
      got.command       = res_if.command;
      got.device_code   = res_if.device_code;
      got.packet_number = res_if.packet_number;
      got.frame_length  = res_if.frame_length;
      sb.check_result(got);
      taken++;
      if (taken % 40 == 0) rx_idle = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin : stimulus
    logic [15:0] lim;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    bytes_sent = 0;
    frames_sent = 0;
    tx_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset limit
    send_frame(32'd1, 8'h00, 8'h00, 16'h0000, 1'b0);
    send_frame(32'd3, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
    tx_idle = 1'b1;
    send_frame(32'd2, 8'h5A, 8'hA5, 16'h1234, 1'b1);
    send_frame(32'd0, 8'h11, 8'h22, 16'h0001, 1'b0);
    send_frame(32'd1051, 8'h33, 8'h44, 16'h0002, 1'b0);
    send_frame(32'hFFFF_FFFF, 8'h80, 8'h01, 16'h8000, 1'b0);
    send_frame(32'h0001_0000, 8'h7F, 8'hFE, 16'h00FF, 1'b0);

    random_traffic(200, 24, 1'b1);
    write_limit(16'd0);
    random_traffic(60, 8, 1'b1);
    write_limit(16'd1);
    random_traffic(80, 4, 1'b1);
    write_limit(16'd10);
    random_traffic(120, 12, 1'b1);
    write_limit(16'hFFFF);
    random_traffic(100, 24, 1'b0);
    lim = 16'($urandom_range(1, 65535));
    write_limit(lim);
    random_traffic(140, 24, lim <= 16'd1050);

    rx_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d frames under limits 1050, 0, 1, 10, 65535 and %0d",
             bytes_sent, frames_sent, lim);
    $display("Checked %0d payload bytes; verdicts: %0d ok, %0d CRC error, %0d length error",
             sb.n_payload, sb.n_ok, sb.n_crc_err, sb.n_len_err);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
